// ===== src/htd_pkg.sv =====
`timescale 1ns / 1ps

package htd_pkg;

    // Default sizes of the code tree and of a loaded code.
    localparam int MAX_NODES_DEF    = 512;
    localparam int MAX_CODE_LEN_DEF = 32;

    // Depth of the command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // Action codes on the input.
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_DECODE = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_SYMBOL = 2'd0;
    localparam logic [1:0] KIND_END    = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_BADLEN  = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_MIDCODE = 3'd4;

    // Operation classes handed from front to back.
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_DECODE,
        OP_END,
        OP_BADLEN
    } t_op;

    // One queued command.
    typedef struct packed {
        t_op         op;
        logic [7:0]  symbol;
        logic [31:0] code_bits;
        logic [5:0]  code_length;
        logic        data_bit;
    } t_q_entry;

    // Write side of the queue.
    typedef struct packed {
        logic     push;
        t_q_entry entry;
    } t_q_wr;

    // Read side of the queue.
    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_rd;

    // Status of the back end seen by the front end.
    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

// ===== src/htd_front.sv =====
`timescale 1ns / 1ps

module htd_front
    import htd_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_symbol,
    input  logic [31:0] i_code_bits,
    input  logic [5:0]  i_code_length,
    input  logic        i_data_bit,
    input  logic        i_q_full,
    input  t_back_stat  i_bstat,
    output t_q_wr       o_q_wr
);

    logic accept;
    logic bad_len;

    // Hold off transfers while the table is cleared or the queue has no room.
    assign busy   = i_q_full | i_bstat.clearing;
    assign accept = start & ~busy;

    // A load with an empty or overlong code is marked here as a bad length.
    assign bad_len = (i_code_length == 6'd0) || (32'(i_code_length) > MAX_CODE_LEN);

    // Classify the item; the unused action code is dropped.
    always_comb begin
        o_q_wr.entry.symbol      = i_symbol;
        o_q_wr.entry.code_bits   = i_code_bits;
        o_q_wr.entry.code_length = i_code_length;
        o_q_wr.entry.data_bit    = i_data_bit;
        o_q_wr.entry.op          = OP_END;
        o_q_wr.push              = 1'b0;
        case (i_action)
            ACT_LOAD: begin
                o_q_wr.entry.op = bad_len ? OP_BADLEN : OP_LOAD;
                o_q_wr.push     = accept;
            end
            ACT_DECODE: begin
                o_q_wr.entry.op = OP_DECODE;
                o_q_wr.push     = accept;
            end
            ACT_END: begin
                o_q_wr.entry.op = OP_END;
                o_q_wr.push     = accept;
            end
            default: begin
                o_q_wr.push = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/htd_queue.sv =====
`timescale 1ns / 1ps

module htd_queue
    import htd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_q_wr i_wr,
    input  logic  i_pop,
    output t_q_rd o_rd,
    output logic  o_full
);

    t_q_entry       r_entry [QDEPTH];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QPW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full     = (r_count == (QPW+1)'(QDEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.entry = r_entry[r_rp];

    assign do_push = i_wr.push & ~o_full;
    assign do_pop  = i_pop & o_rd.valid;

    // Pointer and count update for each transfer in or out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wp] <= i_wr.entry;
        end
    end

endmodule

// ===== src/htd_back.sv =====
`timescale 1ns / 1ps

module htd_back
    import htd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_rd      i_q_rd,
    output logic       o_pop,
    output t_back_stat o_bstat,
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_symbol,
    output logic [2:0] o_status
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int FW = $clog2(MAX_NODES + 1);
    localparam int EW = 8 + 2 * IW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DEC_CHK,
        S_LEAF_CHK,
        S_LD_CHK
    } t_state;

    // Node table: symbol, left child, right child; child zero means none.
    logic [EW-1:0] mem [MAX_NODES];
    logic [EW-1:0] r_rdata;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;

    t_state        r_state,     n_state;
    logic [IW-1:0] r_clr,       n_clr;
    logic [FW-1:0] r_next_free, n_next_free;
    logic [IW-1:0] r_cur,       n_cur;
    logic [IW-1:0] r_node,      n_node;
    logic [5:0]    r_i,         n_i;
    logic [7:0]    r_sym,       n_sym;
    logic [31:0]   r_bits,      n_bits;
    logic          r_bit,       n_bit;
    logic          r_valid,     n_valid;
    logic [1:0]    r_kind,      n_kind;
    logic [7:0]    r_osym,      n_osym;
    logic [2:0]    r_status,    n_status;

    logic [7:0]    rd_sym;
    logic [IW-1:0] rd_left;
    logic [IW-1:0] rd_right;
    logic [5:0]    pos;
    logic          ld_bit;
    logic [IW-1:0] ld_child;
    logic [IW-1:0] dec_next;
    logic          table_full;

    assign rd_sym   = r_rdata[EW-1 -: 8];
    assign rd_left  = r_rdata[2*IW-1:IW];
    assign rd_right = r_rdata[IW-1:0];

    // Code bit for the current load step; positions at or above 32 read as zero.
    assign pos        = r_i - 6'd1;
    assign ld_bit     = (pos < 6'd32) ? r_bits[pos[4:0]] : 1'b0;
    assign ld_child   = ld_bit ? rd_right : rd_left;
    assign dec_next   = r_bit ? rd_right : rd_left;
    assign table_full = (r_next_free >= FW'(MAX_NODES));

    assign o_pop            = (r_state == S_IDLE) & i_q_rd.valid;
    assign o_bstat.clearing = (r_state == S_CLEAR);

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_out_symbol = r_osym;
    assign o_status     = r_status;

    // Table memory with one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Sequencer: clearing pass, command dispatch, tree walks.
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_next_free = r_next_free;
        n_cur       = r_cur;
        n_node      = r_node;
        n_i         = r_i;
        n_sym       = r_sym;
        n_bits      = r_bits;
        n_bit       = r_bit;
        n_valid     = 1'b0;
        n_kind      = r_kind;
        n_osym      = r_osym;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_waddr   = r_node;
        mem_wdata   = r_rdata;
        mem_raddr   = r_node;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == IW'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                mem_raddr = r_cur;
                if (i_q_rd.valid) begin
                    n_sym  = i_q_rd.entry.symbol;
                    n_bits = i_q_rd.entry.code_bits;
                    n_i    = i_q_rd.entry.code_length;
                    n_bit  = i_q_rd.entry.data_bit;
                    case (i_q_rd.entry.op)
                        OP_LOAD: begin
                            mem_raddr = '0;
                            n_node    = '0;
                            n_state   = S_LD_CHK;
                        end
                        OP_DECODE: begin
                            n_state = S_DEC_CHK;
                        end
                        OP_END: begin
                            n_valid  = 1'b1;
                            n_kind   = KIND_END;
                            n_osym   = '0;
                            n_status = (r_cur != '0) ? ST_MIDCODE : ST_OK;
                            n_cur    = '0;
                        end
                        default: begin
                            n_valid  = 1'b1;
                            n_kind   = KIND_ERROR;
                            n_osym   = '0;
                            n_status = ST_BADLEN;
                        end
                    endcase
                end
            end

            // Current node is read; follow the branch for the message bit.
            S_DEC_CHK: begin
                if (dec_next == '0) begin
                    n_valid  = 1'b1;
                    n_kind   = KIND_ERROR;
                    n_osym   = '0;
                    n_status = ST_MISSING;
                    n_cur    = '0;
                    n_state  = S_IDLE;
                end else begin
                    mem_raddr = dec_next;
                    n_node    = dec_next;
                    n_state   = S_LEAF_CHK;
                end
            end

            // Reached node is read; a node with no left child is a leaf.
            S_LEAF_CHK: begin
                if (rd_left == '0) begin
                    n_valid  = 1'b1;
                    n_kind   = KIND_SYMBOL;
                    n_osym   = rd_sym;
                    n_status = ST_OK;
                    n_cur    = '0;
                end else begin
                    n_cur = r_node;
                end
                n_state = S_IDLE;
            end

            // One code bit per visit; the last visit stores the symbol.
            S_LD_CHK: begin
                if (r_i == 6'd0) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_node;
                    mem_wdata = {r_sym, rd_left, rd_right};
                    n_state   = S_IDLE;
                end else if (ld_child == '0) begin
                    if (table_full) begin
                        n_valid  = 1'b1;
                        n_kind   = KIND_ERROR;
                        n_osym   = '0;
                        n_status = ST_FULL;
                        n_state  = S_IDLE;
                    end else begin
                        mem_we      = 1'b1;
                        mem_waddr   = r_node;
                        mem_wdata   = ld_bit ? {rd_sym, rd_left, r_next_free[IW-1:0]}
                                             : {rd_sym, r_next_free[IW-1:0], rd_right};
                        mem_raddr   = r_next_free[IW-1:0];
                        n_node      = r_next_free[IW-1:0];
                        n_next_free = r_next_free + 1'b1;
                        n_i         = r_i - 6'd1;
                    end
                end else begin
                    mem_raddr = ld_child;
                    n_node    = ld_child;
                    n_i       = r_i - 6'd1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_next_free <= FW'(1);
            r_cur       <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next_free <= n_next_free;
            r_cur       <= n_cur;
            r_valid     <= n_valid;
        end
        r_node   <= n_node;
        r_i      <= n_i;
        r_sym    <= n_sym;
        r_bits   <= n_bits;
        r_bit    <= n_bit;
        r_kind   <= n_kind;
        r_osym   <= n_osym;
        r_status <= n_status;
    end

endmodule

// ===== src/huffman_tree_decoder_unit.sv =====
`timescale 1ns / 1ps
// Decode bit: back end steps are queue pop, table read, child read; o_valid is registered
// after the child read, after the table read for a missing branch, at the pop for ends and rejected loads.
// Load: a queue pop, then one synchronous node-table read per code bit.
// A 2-entry queue lets up to two commands be taken while the back end works.
// After reset, busy stays high while the node table is cleared.
// Results are one-cycle strobes on o_valid; the receiver cannot stall them.

module huffman_tree_decoder_unit
    import htd_pkg::*;
#(
    parameter int MAX_NODES    = MAX_NODES_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_symbol,
    input  logic [31:0] i_code_bits,
    input  logic [5:0]  i_code_length,
    input  logic        i_data_bit,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_out_symbol,
    output logic [2:0]  o_status
);

    t_q_wr      q_wr;
    t_q_rd      q_rd;
    logic       q_full;
    logic       q_pop;
    t_back_stat bstat;

    // Front end: accepts and classifies items.
    htd_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .i_data_bit    (i_data_bit),
        .i_q_full      (q_full),
        .i_bstat       (bstat),
        .o_q_wr        (q_wr)
    );

    // Command queue between the two ends.
    htd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_pop   (q_pop),
        .o_rd    (q_rd),
        .o_full  (q_full)
    );

    // Back end: node table and tree walks.
    htd_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_rd       (q_rd),
        .o_pop        (q_pop),
        .o_bstat      (bstat),
        .o_valid      (o_valid),
        .o_kind       (o_kind),
        .o_out_symbol (o_out_symbol),
        .o_status     (o_status)
    );

endmodule

// ===== tb/tb_huffman_tree_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_huffman_tree_decoder_unit;
    import htd_pkg::*;

    // Action code that the block ignores.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Cycles without any transfer before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 600;

    // One result as it appears on the output ports.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] sym;
        logic [2:0] status;
    } t_tree_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_action;
    logic [7:0]  i_symbol;
    logic [31:0] i_code_bits;
    logic [5:0]  i_code_length;
    logic        i_data_bit;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_symbol;
    logic [2:0]  o_status;

    huffman_tree_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .i_data_bit    (i_data_bit),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_out_symbol  (o_out_symbol),
        .o_status      (o_status)
    );

    // Shadow copy of the code tree and the decode position.
    logic [7:0]  tree_sym   [MAX_NODES_DEF];
    int unsigned tree_left  [MAX_NODES_DEF];
    int unsigned tree_right [MAX_NODES_DEF];
    int unsigned free_idx;
    int unsigned walk_node;

    // Results the block owes, oldest first.
    t_tree_result decode_results_q[$];
    t_tree_result head_result;

    // Codes loaded during random traffic, replayed as decode streams.
    logic [31:0] code_words[$];
    int          code_lens[$];

    bit gaps_on;
    int items_sent;
    int loads_sent;
    int decodes_sent;
    int ends_sent;
    int results_seen;
    int mismatch_count;
    int idle_cycles;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one accepted item to the shadow tree and queue any result it causes.
    task automatic tree_walk_step(input logic [1:0] act, input logic [7:0] sym,
                                  input logic [31:0] bits, input logic [5:0] len,
                                  input logic dbit);
        int unsigned  n;
        int unsigned  child;
        int unsigned  nxt;
        int           i;
        logic         b;
        bit           stopped;
        t_tree_result r;
        r = '0;
        case (act)
            ACT_LOAD: begin
                loads_sent++;
                if (len == 0 || len > MAX_CODE_LEN_DEF) begin
                    r.kind   = KIND_ERROR;
                    r.status = ST_BADLEN;
                    decode_results_q.push_back(r);
                end else begin
                    n = 0;
                    stopped = 1'b0;
                    // Walk from the first code bit, allocating missing children.
                    for (i = len; i > 0 && !stopped; i--) begin
                        b = bits[i-1];
                        child = b ? tree_right[n] : tree_left[n];
                        if (child == 0) begin
                            if (free_idx >= MAX_NODES_DEF) begin
                                r.kind   = KIND_ERROR;
                                r.status = ST_FULL;
                                decode_results_q.push_back(r);
                                stopped = 1'b1;
                            end else begin
                                if (b) tree_right[n] = free_idx;
                                else   tree_left[n]  = free_idx;
                                child = free_idx;
                                free_idx++;
                            end
                        end
                        if (!stopped) n = child;
                    end
                    if (!stopped) tree_sym[n] = sym;
                end
            end
            ACT_DECODE: begin
                decodes_sent++;
                nxt = dbit ? tree_right[walk_node] : tree_left[walk_node];
                if (nxt == 0) begin
                    walk_node = 0;
                    r.kind    = KIND_ERROR;
                    r.status  = ST_MISSING;
                    decode_results_q.push_back(r);
                end else if (tree_left[nxt] == 0) begin
                    // A node without a left child is a leaf.
                    walk_node = 0;
                    r.kind    = KIND_SYMBOL;
                    r.sym     = tree_sym[nxt];
                    r.status  = ST_OK;
                    decode_results_q.push_back(r);
                end else begin
                    walk_node = nxt;
                end
            end
            ACT_END: begin
                ends_sent++;
                r.kind    = KIND_END;
                r.status  = (walk_node != 0) ? ST_MIDCODE : ST_OK;
                walk_node = 0;
                decode_results_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Drive one item and hold it until the block takes the transfer.
    task automatic send_item(input logic [1:0] act, input logic [7:0] sym,
                             input logic [31:0] bits, input logic [5:0] len,
                             input logic dbit);
        int gap;
        gap = gaps_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action      <= act;
        i_symbol      <= sym;
        i_code_bits   <= bits;
        i_code_length <= len;
        i_data_bit    <= dbit;
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        tree_walk_step(act, sym, bits, len, dbit);
        if (act != ACT_UNUSED) items_sent++;
        @(negedge i_clk);
    endtask

    task automatic load_code(input logic [7:0] sym, input logic [31:0] bits,
                             input logic [5:0] len);
        send_item(ACT_LOAD, sym, bits, len, 1'($urandom()));
    endtask

    // Send the bits of a code, first bit first, as decode items.
    task automatic decode_bits(input logic [31:0] bits, input int len);
        int i;
        for (i = len; i > 0; i--)
            send_item(ACT_DECODE, 8'($urandom()), $urandom(), 6'($urandom()), bits[i-1]);
    endtask

    task automatic end_message();
        send_item(ACT_END, 8'($urandom()), $urandom(), 6'($urandom()), 1'($urandom()));
    endtask

    // Decoding and ending on a tree that holds no codes.
    task automatic test_empty_tree();
        decode_bits(32'b0, 1);
        decode_bits(32'b1, 1);
        end_message();
    endtask

    // A small prefix code, leaf rules, reloads and interleaved loads.
    task automatic test_small_code();
        load_code(8'h41, 32'b0,   6'd1);
        load_code(8'h42, 32'b10,  6'd2);
        load_code(8'h43, 32'b110, 6'd3);
        load_code(8'h44, 32'b111, 6'd3);
        decode_bits(32'b0, 1);
        decode_bits(32'b10, 2);
        decode_bits(32'b110, 3);
        decode_bits(32'b111, 3);
        // The message stops inside a code.
        decode_bits(32'b1, 1);
        end_message();
        // A right child alone leaves the node a leaf.
        load_code(8'h45, 32'b01, 6'd2);
        decode_bits(32'b0, 1);
        // Reloading overwrites the symbol.
        load_code(8'hFF, 32'b0, 6'd1);
        decode_bits(32'b0, 1);
        // A load between decode bits keeps the decode position.
        decode_bits(32'b1, 1);
        load_code(8'h00, 32'b1101, 6'd4);
        decode_bits(32'b0, 1);
        // An internal node with only a left branch.
        load_code(8'h46, 32'b1000, 6'd4);
        decode_bits(32'b101, 3);
        decode_bits(32'b1000, 4);
        end_message();
    endtask

    // Code lengths out of range, the longest legal code, and the unused action.
    task automatic test_length_errors();
        load_code(8'hFF, 32'hFFFF_FFFF, 6'd0);
        load_code(8'hFF, 32'hFFFF_FFFF, 6'd33);
        load_code(8'hFF, 32'hFFFF_FFFF, 6'd63);
        load_code(8'h5A, 32'hFFFF_FFFF, 6'd32);
        send_item(ACT_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F, 1'b1);
        end_message();
    endtask

    // Mostly replayed codes with random content, plus noise and broken streams.
    task automatic test_random_traffic();
        int          goal;
        int          r;
        int          k;
        int          len;
        int          cut;
        logic [31:0] bits;
        goal = items_sent + RANDOM_ITEMS;
        load_code(8'h5A, 32'h0, 6'd32);
        code_words.push_back(32'h0);
        code_lens.push_back(32);
        while (items_sent < goal) begin
            if ($urandom_range(0, 39) == 0) gaps_on = ~gaps_on;
            r = $urandom_range(0, 99);
            if (r < 12) begin
                bits = $urandom();
                if ($urandom_range(0, 19) == 0) begin
                    len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 63);
                end else if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(7, 32);
                end else begin
                    len = $urandom_range(1, 6);
                end
                load_code(8'($urandom()), bits, 6'(len));
                if (len >= 1 && len <= MAX_CODE_LEN_DEF) begin
                    code_words.push_back(bits);
                    code_lens.push_back(len);
                end
            end else if (r < 18) begin
                end_message();
            end else if (r < 24) begin
                decode_bits($urandom(), 1);
            end else if (r < 26) begin
                send_item(ACT_UNUSED, 8'($urandom()), $urandom(), 6'($urandom()),
                          1'($urandom()));
            end else begin
                k   = $urandom_range(0, code_words.size() - 1);
                len = code_lens[k];
                // Now and then a stream breaks off partway through a code.
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
                decode_bits(code_words[k] >> (len - cut), cut);
            end
        end
        end_message();
    endtask

    // Fill the node table, then load and decode on a full table.
    task automatic test_table_full();
        int guard;
        int k;
        gaps_on = 1'b1;
        guard = 0;
        while (free_idx < MAX_NODES_DEF && guard < 200) begin
            load_code(8'($urandom()), $urandom(), 6'd32);
            guard++;
        end
        repeat (3) load_code(8'($urandom()), $urandom(), 6'd32);
        // A reload that needs no new node still succeeds.
        load_code(8'hA5, 32'h0, 6'd32);
        decode_bits(32'h0, 32);
        repeat (10) begin
            k = $urandom_range(0, code_words.size() - 1);
            decode_bits(code_words[k], code_lens[k]);
        end
        decode_bits($urandom(), 8);
        end_message();
    endtask

    // Compare each result with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            results_seen++;
            if (decode_results_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: kind=%0d symbol=%02h status=%0d",
                             o_kind, o_out_symbol, o_status);
            end else begin
                head_result = decode_results_q.pop_front();
                if (o_kind !== head_result.kind || o_out_symbol !== head_result.sym ||
                    o_status !== head_result.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected kind=%0d symbol=%02h status=%0d, %s%0d %s%02h %s%0d",
                                 head_result.kind, head_result.sym, head_result.status,
                                 "got kind=", o_kind, "symbol=", o_out_symbol,
                                 "status=", o_status);
                end
            end
        end
    end

    // Count cycles in which no transfer happens on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Main sequence.
    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_action      = ACT_LOAD;
        i_symbol      = '0;
        i_code_bits   = '0;
        i_code_length = '0;
        i_data_bit    = 1'b0;
        gaps_on       = 1'b1;
        free_idx      = 1;
        walk_node     = 0;
        for (int n = 0; n < MAX_NODES_DEF; n++) begin
            tree_sym[n]   = '0;
            tree_left[n]  = 0;
            tree_right[n] = 0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_tree();
        test_small_code();
        test_length_errors();
        test_random_traffic();
        test_table_full();

        start <= 1'b0;
        while (decode_results_q.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (decode_results_q.size() != 0) mismatch_count++;

        $display("covered %0d items: %0d loads, %0d decode bits, %0d message ends",
                 items_sent, loads_sent, decodes_sent, ends_sent);
        $display("checked %0d results, %0d tree nodes in use, %0d mismatches",
                 results_seen, free_idx, mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/htd_pkg.sv
src/htd_front.sv
src/htd_queue.sv
src/htd_back.sv
src/huffman_tree_decoder_unit.sv
tb/tb_huffman_tree_decoder_unit.sv
